// File: src/jbhc_pkg.sv
// Package for the JPEG baseline header checker.
// Field widths, status codes, marker constants, the queue word type and marker helpers.
// No dependencies.
package jbhc_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned LenW     = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned DimW     = 16;
  localparam int unsigned StrideW  = 17;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgMaxDim   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxBytes = 2'd1;

  localparam logic [DimW-1:0]  MaxDimReset   = 16'd4096;
  localparam logic [SizeW-1:0] MaxBytesReset = 32'd4194304;

  localparam logic [7:0] MrkFill = 8'hff;
  localparam logic [7:0] MrkSoi  = 8'hd8;
  localparam logic [7:0] MrkEoi  = 8'hd9;
  localparam logic [7:0] MrkSos  = 8'hda;
  localparam logic [7:0] MrkSof0 = 8'hc0;
  localparam logic [7:0] MrkDht  = 8'hc4;
  localparam logic [7:0] MrkJpg  = 8'hc8;
  localparam logic [7:0] MrkDac  = 8'hcc;
  localparam logic [7:0] MrkRst0 = 8'hd0;
  localparam logic [7:0] MrkRst7 = 8'hd7;
  localparam logic [7:0] MrkTem  = 8'h01;
  localparam logic [7:0] MrkZero = 8'h00;
  localparam logic [7:0] Prec8   = 8'h08;

  typedef enum logic [StatusW-1:0] {
    StOk    = 3'd0,
    StArg   = 3'd1,
    StBad   = 3'd2,
    StUnsup = 3'd3,
    StSize  = 3'd4
  } jbhc_status_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last;
    logic             total_lt4;
    logic [LenW-1:0]  rem;
  } jbhc_item_t;

  function automatic logic marker_illegal(logic [7:0] m);
    return m == MrkZero || m == MrkTem || m == MrkSoi || m == MrkEoi ||
           (m >= MrkRst0 && m <= MrkRst7);
  endfunction

  function automatic logic marker_is_sof(logic [7:0] m);
    return m[7:4] == MrkSof0[7:4] && m != MrkDht && m != MrkJpg && m != MrkDac;
  endfunction

endpackage

// File: src/jbhc_if.sv
// Stream interfaces of the JPEG baseline header checker: byte input and verdict output.
// Depends on jbhc_pkg.
interface jbhc_in_if;
  logic                         valid;
  logic                         ready;
  logic [jbhc_pkg::DataW-1:0]   data_byte;
  logic [jbhc_pkg::LenW-1:0]    frame_length;

  modport source (output valid, data_byte, frame_length, input ready);
  modport sink   (input valid, data_byte, frame_length, output ready);
endinterface

interface jbhc_out_if;
  logic                          valid;
  logic                          ready;
  logic [jbhc_pkg::StatusW-1:0]  status;
  logic [jbhc_pkg::DimW-1:0]     width;
  logic [jbhc_pkg::DimW-1:0]     height;
  logic [jbhc_pkg::StrideW-1:0]  stride;
  logic [jbhc_pkg::SizeW-1:0]    image_bytes;

  modport source (output valid, status, width, height, stride, image_bytes, input ready);
  modport sink   (input valid, status, width, height, stride, image_bytes, output ready);
endinterface

// File: src/jbhc_front.sv
// Front end: accepts stream bytes, tracks position in the frame and tags each word.
// Depends on jbhc_pkg and jbhc_in_if.
module jbhc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  jbhc_in_if.sink              in_i,
  output jbhc_pkg::jbhc_item_t item_o,
  output logic                 item_valid_o,
  input  logic                 item_ready_i
);
  import jbhc_pkg::*;

  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] total_q;
  logic [LenW-1:0] tot;
  logic            first;
  logic            last;
  logic            acc;

  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;
  assign acc          = in_i.valid && item_ready_i;

  assign first = (pos_q == '0);
  assign tot   = first ? in_i.frame_length : total_q;
  assign last  = ({1'b0, pos_q} + 33'd1) >= {1'b0, tot};
  assign pos_d = last ? '0 : pos_q + 32'd1;

  always_comb begin
    item_o.data_byte = in_i.data_byte;
    item_o.last      = last;
    item_o.total_lt4 = tot < 32'd4;
    item_o.rem       = tot - pos_q - 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      total_q <= '0;
    end else if (acc) begin
      pos_q   <= pos_d;
      total_q <= tot;
    end
  end

endmodule

// File: src/jbhc_fifo.sv
// Short queue of tagged words between front end and parser.
// Depends on jbhc_pkg.
module jbhc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jbhc_pkg::jbhc_item_t push_data_i,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  output jbhc_pkg::jbhc_item_t pop_data_o,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i
);
  import jbhc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jbhc_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: src/jbhc_back.sv
// Parser: walks marker segments word by word, checks SOF0 and SOS, registers the verdict.
// Holds the configuration registers. Depends on jbhc_pkg and jbhc_out_if.
module jbhc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [jbhc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jbhc_pkg::CfgDataW-1:0] cfg_data_i,
  input  jbhc_pkg::jbhc_item_t item_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  jbhc_out_if.source           out_o
);
  import jbhc_pkg::*;

  localparam logic [3:0] PhStart  = 4'd0;
  localparam logic [3:0] PhSoi2   = 4'd1;
  localparam logic [3:0] PhWantFf = 4'd2;
  localparam logic [3:0] PhFill   = 4'd3;
  localparam logic [3:0] PhLenHi  = 4'd4;
  localparam logic [3:0] PhLenLo  = 4'd5;
  localparam logic [3:0] PhSof    = 4'd6;
  localparam logic [3:0] PhSkip   = 4'd7;
  localparam logic [3:0] PhSos    = 4'd8;
  localparam logic [3:0] PhDone   = 4'd9;

  logic [DimW-1:0]  max_dim_q;
  logic [SizeW-1:0] max_bytes_q;

  logic [3:0]       phase_q, phase_d;
  logic [15:0]      seglen_q, seglen_d;
  logic [15:0]      segcnt_q, segcnt_d;
  logic [7:0]       marker_q, marker_d;
  logic             hdr_q, hdr_d;
  logic [1:0]       comps_q, comps_d;
  logic             prec_bad_q, prec_bad_d;
  logic [DimW-1:0]  width_q, width_d;
  logic [DimW-1:0]  height_q, height_d;
  logic [31:0]      prod_q, prod_d;
  logic             verdict_q, verdict_d;

  logic             out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [DimW-1:0]  out_width_q, out_height_q;
  logic [StrideW-1:0] out_stride_q;
  logic [SizeW-1:0] out_size_q;

  logic [7:0]       b;
  logic [15:0]      seglen_lo;
  logic [15:0]      wfull;
  logic [15:0]      sos_len;
  logic [15:0]      sof_len;
  logic             pop, decided, emit;
  jbhc_status_e     st;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign pop          = item_valid_i && item_ready_o;
  assign b            = item_i.data_byte;
  assign seglen_lo    = {seglen_q[15:8], b};
  assign wfull        = {width_q[15:8], b};
  assign sos_len      = 16'd6 + {7'd0, b, 1'b0};
  assign sof_len      = 16'd8 + {8'd0, b} + {7'd0, b, 1'b0};

  always_comb begin
    phase_d    = phase_q;
    seglen_d   = seglen_q;
    segcnt_d   = segcnt_q;
    marker_d   = marker_q;
    hdr_d      = hdr_q;
    comps_d    = comps_q;
    prec_bad_d = prec_bad_q;
    width_d    = width_q;
    height_d   = height_q;
    prod_d     = prod_q;
    verdict_d  = verdict_q;
    decided    = 1'b0;
    st         = StBad;
    if (!verdict_q) begin
      case (phase_q)
        PhStart: begin
          if (item_i.total_lt4 || b != MrkFill) begin
            decided = 1'b1;
            st      = StArg;
          end else begin
            phase_d = PhSoi2;
          end
        end
        PhSoi2: begin
          if (b != MrkSoi) begin
            decided = 1'b1;
            st      = StArg;
          end else begin
            phase_d = PhWantFf;
          end
        end
        PhWantFf: begin
          if (b != MrkFill) begin
            decided = 1'b1;
          end else begin
            phase_d = PhFill;
          end
        end
        PhFill: begin
          if (b != MrkFill) begin
            marker_d = b;
            if (marker_illegal(b) || item_i.rem < 32'd2) begin
              decided = 1'b1;
            end else begin
              phase_d = PhLenHi;
            end
          end
        end
        PhLenHi: begin
          seglen_d = {b, 8'd0};
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          seglen_d = seglen_lo;
          segcnt_d = 16'd2;
          if (seglen_lo < 16'd2 ||
              {17'd0, seglen_lo} > ({1'b0, item_i.rem} + 33'd2)) begin
            decided = 1'b1;
          end else if (marker_q == MrkSos) begin
            if (!hdr_q || seglen_lo < 16'd6) begin
              decided = 1'b1;
            end else begin
              phase_d = PhSos;
            end
          end else if (marker_is_sof(marker_q)) begin
            if (hdr_q || marker_q != MrkSof0 || seglen_lo < 16'd8) begin
              decided = 1'b1;
              st      = StUnsup;
            end else begin
              phase_d = PhSof;
            end
          end else begin
            phase_d = (seglen_lo == 16'd2) ? PhWantFf : PhSkip;
          end
        end
        PhSos: begin
          decided = 1'b1;
          if (b == 8'd0 || b > {6'd0, comps_q} || seglen_q != sos_len) begin
            st = StUnsup;
          end else begin
            st = StOk;
          end
        end
        PhSof: begin
          case (segcnt_q)
            16'd2: prec_bad_d = (b != Prec8);
            16'd3: height_d = {b, 8'd0};
            16'd4: height_d = {height_q[15:8], b};
            16'd5: width_d = {b, 8'd0};
            16'd6: begin
              width_d = wfull;
              prod_d  = {16'd0, height_q} * {16'd0, wfull};
            end
            default: begin
              if (prec_bad_q || (b != 8'd1 && b != 8'd3) || seglen_q != sof_len) begin
                decided = 1'b1;
                st      = StUnsup;
              end else if (width_q == '0 || height_q == '0 ||
                           width_q > max_dim_q || height_q > max_dim_q) begin
                decided = 1'b1;
                st      = StSize;
              end else if (prod_q[31] ||
                           {prod_q, 1'b0} > {1'b0, max_bytes_q}) begin
                decided = 1'b1;
                st      = StSize;
              end else begin
                comps_d = b[1:0];
                hdr_d   = 1'b1;
              end
            end
          endcase
          segcnt_d = segcnt_q + 16'd1;
          if (segcnt_d >= 16'd8) begin
            phase_d = (segcnt_d >= seglen_q) ? PhWantFf : PhSkip;
          end
        end
        PhSkip: begin
          segcnt_d = segcnt_q + 16'd1;
          if (segcnt_d >= seglen_q) begin
            phase_d = PhWantFf;
          end
        end
        default: ;
      endcase
    end
    emit = decided || (item_i.last && !verdict_q);
    if (!decided) begin
      st = StBad;
    end
    if (emit) begin
      verdict_d = 1'b1;
      phase_d   = PhDone;
    end
    if (item_i.last) begin
      phase_d    = PhStart;
      seglen_d   = '0;
      segcnt_d   = '0;
      marker_d   = '0;
      hdr_d      = 1'b0;
      comps_d    = '0;
      prec_bad_d = 1'b0;
      width_d    = '0;
      height_d   = '0;
      verdict_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q   <= MaxDimReset;
      max_bytes_q <= MaxBytesReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgMaxDim) begin
        max_dim_q <= cfg_data_i[DimW-1:0];
      end else if (cfg_idx_i == CfgMaxBytes) begin
        max_bytes_q <= cfg_data_i[SizeW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhStart;
      seglen_q   <= '0;
      segcnt_q   <= '0;
      marker_q   <= '0;
      hdr_q      <= 1'b0;
      comps_q    <= '0;
      prec_bad_q <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      verdict_q  <= 1'b0;
    end else if (pop) begin
      phase_q    <= phase_d;
      seglen_q   <= seglen_d;
      segcnt_q   <= segcnt_d;
      marker_q   <= marker_d;
      hdr_q      <= hdr_d;
      comps_q    <= comps_d;
      prec_bad_q <= prec_bad_d;
      width_q    <= width_d;
      height_q   <= height_d;
      verdict_q  <= verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q <= prod_d;
    end
    if (pop && emit) begin
      out_status_q <= st;
      if (st == StOk) begin
        out_width_q  <= width_q;
        out_height_q <= height_q;
        out_stride_q <= {width_q, 1'b0};
        out_size_q   <= {prod_q[30:0], 1'b0};
      end else begin
        out_width_q  <= '0;
        out_height_q <= '0;
        out_stride_q <= '0;
        out_size_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.width       = out_width_q;
  assign out_o.height      = out_height_q;
  assign out_o.stride      = out_stride_q;
  assign out_o.image_bytes = out_size_q;

endmodule

// File: src/jpeg_baseline_header_checker.sv
// Top level of the JPEG baseline header checker: front end, word queue and parser.
// Depends on jbhc_pkg, jbhc_if, jbhc_front, jbhc_fifo and jbhc_back.
//
// Usage: stream a frame on in_i, one byte per word, each with the frame's total
// byte count (only the count on the first byte of a frame is used). For every
// frame exactly one verdict word leaves on out_o: status, and for status ok the
// SOF0 width, height, RGB565 stride and image byte count. Bytes after the verdict
// are consumed and dropped until the frame ends.
// Throughput: one byte per cycle unless out_o stalls, one parser step per byte.
// With the queue empty, the deciding byte is registered in the queue and then in the
// parser's output register, from which the verdict is valid on out_o.
// The SOF0 size product is registered on the width byte and compared on the
// component-count byte, so the parser does not stall for it.
// Reset clears the frame state and the queue, and loads max_dimension 4096 and
// max_decoded_bytes 4194304. Configuration is written through cfg_we_i, index 0
// or 1; other indexes are ignored.
// When out_o stalls, the held verdict stays registered, the queue absorbs up to
// QueueDepth bytes, then in_i.ready drops.
module jpeg_baseline_header_checker #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jbhc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jbhc_pkg::CfgDataW-1:0] cfg_data_i,
  jbhc_in_if.sink                       in_i,
  jbhc_out_if.source                    out_o
);
  import jbhc_pkg::*;

  jbhc_item_t front_item, back_item;
  logic       front_valid, front_ready;
  logic       back_valid, back_ready;

  jbhc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  jbhc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  jbhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .out_o        (out_o)
  );

endmodule

// File: bench/tb_jpeg_baseline_header_checker.sv
// Testbench for jpeg_baseline_header_checker: streams JPEG header frames one byte word at a
// time under five register settings and checks each verdict against a local parser model.
// Depends on jbhc_pkg, jbhc_if and the checker RTL.
module tb_jpeg_baseline_header_checker;
  import jbhc_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned HoldOffCycles = 120;
  localparam int unsigned ItemTarget    = 1350;
  localparam int unsigned PhaseCount    = 5;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef enum logic [3:0] {
    PStart, PSoi2, PWantFf, PFill, PLenHi, PLenLo, PSof, PSkip, PSos, PDone
  } parse_phase_e;

  typedef enum int {
    FlNone, FlPrecision, FlComps, FlSosCount, FlSosShort, FlNoSof, FlTwoSof, FlOtherSof,
    FlIllegal, FlShortSeg, FlLongSeg, FlFlip, FlTruncate, FlNoise
  } frame_flaw_e;

  typedef struct packed {
    jbhc_status_e         status;
    logic [DimW-1:0]      width;
    logic [DimW-1:0]      height;
    logic [StrideW-1:0]   stride;
    logic [SizeW-1:0]     image_bytes;
  } verdict_t;

  class header_verdict_model;
    logic [DimW-1:0]  max_dim;
    logic [SizeW-1:0] max_bytes;
    parse_phase_e     phase;
    longint unsigned  pos;
    longint unsigned  total;
    logic [15:0]      seg_len;
    logic [15:0]      seg_cnt;
    logic [7:0]       marker;
    bit               sof_seen;
    bit               prec_bad;
    bit               verdict_done;
    logic [1:0]       comps;
    logic [DimW-1:0]  img_w;
    logic [DimW-1:0]  img_h;
    verdict_t         verdicts_due[$];
    int unsigned      mismatches;
    int unsigned      bytes_taken;
    int unsigned      status_count[5];

    function new();
      max_dim = MaxDimReset;
      max_bytes = MaxBytesReset;
      restart_frame();
    endfunction

    function void restart_frame();
      phase = PStart;
      pos = 0;
      total = 0;
      seg_len = '0;
      seg_cnt = '0;
      marker = '0;
      sof_seen = 0;
      prec_bad = 0;
      verdict_done = 0;
      comps = '0;
      img_w = '0;
      img_h = '0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgMaxDim:   max_dim = data[DimW-1:0];
        CfgMaxBytes: max_bytes = data[SizeW-1:0];
        default: ;
      endcase
    endfunction

    function bit decide(logic [7:0] b, output jbhc_status_e st);
      longint unsigned prod;
      st = StBad;
      case (phase)
        PStart: begin
          if (total < 4 || b != MrkFill) begin
            st = StArg;
            return 1;
          end
          phase = PSoi2;
        end
        PSoi2: begin
          if (b != MrkSoi) begin
            st = StArg;
            return 1;
          end
          phase = PWantFf;
        end
        PWantFf: begin
          if (b != MrkFill) return 1;
          phase = PFill;
        end
        PFill: begin
          if (b == MrkFill) return 0;
          marker = b;
          if (b == MrkZero || b == MrkTem || b == MrkSoi || b == MrkEoi ||
              (b >= MrkRst0 && b <= MrkRst7)) return 1;
          if (total - (pos + 1) < 2) return 1;
          phase = PLenHi;
        end
        PLenHi: begin
          seg_len = {b, 8'h00};
          phase = PLenLo;
        end
        PLenLo: begin
          seg_len[7:0] = b;
          seg_cnt = 16'd2;
          if (seg_len < 2 || 64'(seg_len) > total - (pos - 1)) return 1;
          if (marker == MrkSos) begin
            if (!sof_seen || seg_len < 6) return 1;
            phase = PSos;
          end else if (marker[7:4] == MrkSof0[7:4] && marker != MrkDht &&
                       marker != MrkJpg && marker != MrkDac) begin
            if (sof_seen || marker != MrkSof0 || seg_len < 8) begin
              st = StUnsup;
              return 1;
            end
            phase = PSof;
          end else begin
            phase = (seg_len == 2) ? PWantFf : PSkip;
          end
        end
        PSos: begin
          st = (b == 0 || b > comps || seg_len != 6 + 2 * b) ? StUnsup : StOk;
          return 1;
        end
        PSof: begin
          case (seg_cnt)
            16'd2: prec_bad = (b != Prec8);
            16'd3: img_h = {b, 8'h00};
            16'd4: img_h[7:0] = b;
            16'd5: img_w = {b, 8'h00};
            16'd6: img_w[7:0] = b;
            default: begin
              if (prec_bad || (b != 1 && b != 3) || seg_len != 8 + 3 * b) begin
                st = StUnsup;
                return 1;
              end
              if (img_w == 0 || img_h == 0 || img_w > max_dim || img_h > max_dim) begin
                st = StSize;
                return 1;
              end
              prod = 64'(img_w) * 2 * 64'(img_h);
              if (prod > 64'(max_bytes) || prod > 64'hffff_ffff) begin
                st = StSize;
                return 1;
              end
              comps = b[1:0];
              sof_seen = 1;
            end
          endcase
          seg_cnt++;
          if (seg_cnt >= 8) phase = (seg_cnt >= seg_len) ? PWantFf : PSkip;
        end
        PSkip: begin
          seg_cnt++;
          if (seg_cnt >= seg_len) phase = PWantFf;
        end
        default: ;
      endcase
      return 0;
    endfunction

    function void take_byte(logic [7:0] b, logic [LenW-1:0] len);
      jbhc_status_e st;
      bit last;
      bit emit;
      verdict_t v;
      st = StBad;
      emit = 0;
      bytes_taken++;
      if (phase == PStart) total = 64'(len);
      last = (pos + 1 >= total);
      if (!verdict_done) begin
        emit = decide(b, st) || last;
      end
      if (emit) begin
        v = '0;
        v.status = st;
        if (st == StOk) begin
          v.width = img_w;
          v.height = img_h;
          v.stride = {img_w, 1'b0};
          v.image_bytes = 32'(64'(img_w) * 2 * 64'(img_h));
        end
        verdicts_due.push_back(v);
        verdict_done = 1;
        phase = PDone;
      end
      if (last) restart_frame();
      else pos++;
    endfunction

    function void note_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: verdict with none pending, expected nothing, actual status %0d",
                 $time, got.status);
        return;
      end
      want = verdicts_due.pop_front();
      status_count[want.status]++;
      note_field("status", want.status, got.status);
      note_field("width", want.width, got.width);
      note_field("height", want.height, got.height);
      note_field("stride", want.stride, got.stride);
      note_field("image_bytes", want.image_bytes, got.image_bytes);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  bit                  gaps_on = 1'b1;
  bit                  hold_req = 1'b0;
  int unsigned         quiet_cycles = 0;
  int unsigned         frames_sent = 0;
  logic [7:0]          frame_q[$];
  logic [7:0]          misc_markers[7] = '{8'he0, 8'hdb, 8'hdd, 8'hfe, MrkDht, MrkJpg, MrkDac};
  header_verdict_model model;

  jbhc_in_if  byte_if ();
  jbhc_out_if verdict_if ();

  jpeg_baseline_header_checker u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (byte_if),
    .out_o      (verdict_if)
  );

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    verdict_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HoldOffCycles;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        verdict_if.ready <= 1'b0;
      end else begin
        verdict_if.ready <= !(gaps_on && $urandom_range(99) < 11);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && verdict_if.valid && verdict_if.ready) begin
      model.match_verdict(verdict_t'{jbhc_status_e'(verdict_if.status), verdict_if.width,
                                     verdict_if.height, verdict_if.stride,
                                     verdict_if.image_bytes});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (byte_if.valid && byte_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic [LenW-1:0] len);
    while (gaps_on && $urandom_range(99) < 11) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.frame_length <= len;
    do @(posedge clk); while (!byte_if.ready);
    model.take_byte(b, len);
    @(negedge clk);
  endtask

  task automatic send_frame(logic [LenW-1:0] total);
    int unsigned span;
    span = (total == 0) ? 1 : total;
    for (int unsigned i = 0; i < span; i++) begin
      send_byte(i < frame_q.size() ? frame_q[i] : 8'($urandom),
                (i == 0 || $urandom_range(1)) ? total : $urandom);
    end
    frames_sent++;
  endtask

  task automatic put_segment(logic [7:0] m, logic [15:0] len, int unsigned body);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) frame_q.push_back(MrkFill);
    frame_q.push_back(MrkFill);
    frame_q.push_back(m);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    repeat (body) frame_q.push_back(8'($urandom));
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(9))
      0: return 16'd0;
      1, 2: return model.max_dim;
      3: return model.max_dim + 16'd1;
      4: return 16'hffff;
      5: return 16'd1;
      6: return 16'($urandom_range(1, model.max_dim));
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic build_frame(frame_flaw_e flaw, logic [15:0] w, logic [15:0] h);
    int unsigned n_comp;
    int unsigned n_field;
    int unsigned len_units;
    int unsigned seg;
    logic [7:0]  m;
    n_comp = 1;
    frame_q.delete();
    frame_q.push_back(MrkFill);
    frame_q.push_back(MrkSoi);
    if (flaw == FlNoise) begin
      if ($urandom_range(1)) frame_q.delete();
      repeat ($urandom_range(2, 30)) frame_q.push_back($urandom_range(3) ? 8'($urandom) : MrkFill);
      return;
    end
    if (flaw == FlIllegal) begin
      case ($urandom_range(4))
        0: m = MrkZero;
        1: m = MrkTem;
        2: m = MrkSoi;
        3: m = MrkEoi;
        default: m = MrkRst0 + 8'($urandom_range(MrkRst7 - MrkRst0));
      endcase
      put_segment(m, 16'd4, 2);
    end
    if (flaw == FlShortSeg) put_segment(misc_markers[0], 16'($urandom_range(1)), 0);
    if (flaw == FlLongSeg) put_segment(misc_markers[1], 16'($urandom_range(16'h100, 16'hffff)), 4);
    repeat ($urandom_range(1)) begin
      seg = $urandom_range(2, 8);
      put_segment(misc_markers[$urandom_range(6)], 16'(seg), seg - 2);
    end
    if (flaw != FlNoSof) begin
      n_comp = $urandom_range(1) ? 3 : 1;
      n_field = n_comp;
      len_units = n_comp;
      if (flaw == FlComps) begin
        n_field = $urandom_range(4);
        len_units = $urandom_range(4);
      end
      m = MrkSof0;
      if (flaw == FlOtherSof) begin
        m = 8'($urandom_range(MrkSof0 + 1, 8'hcf));
        if (m == MrkDht || m == MrkJpg || m == MrkDac) m = m + 8'd1;
      end
      put_segment(m, 16'(8 + 3 * len_units), 0);
      frame_q.push_back(flaw == FlPrecision ? 8'($urandom_range(15)) : Prec8);
      frame_q.push_back(h[15:8]);
      frame_q.push_back(h[7:0]);
      frame_q.push_back(w[15:8]);
      frame_q.push_back(w[7:0]);
      frame_q.push_back(8'(n_field));
      repeat (3 * len_units) frame_q.push_back(8'($urandom));
      if (flaw == FlTwoSof) put_segment(MrkSof0, 16'd11, 9);
    end
    if ($urandom_range(2) == 0) put_segment(MrkDht, 16'd6, 4);
    if (flaw == FlSosShort) begin
      put_segment(MrkSos, 16'($urandom_range(2, 5)), 0);
    end else begin
      n_field = $urandom_range(1, n_comp);
      len_units = n_field;
      if (flaw == FlSosCount) begin
        n_field = $urandom_range(4);
        len_units = $urandom_range(4);
      end
      put_segment(MrkSos, 16'(6 + 2 * len_units), 0);
      frame_q.push_back(8'(n_field));
      repeat (2 * len_units + 3) frame_q.push_back(8'($urandom));
    end
    if (flaw == FlFlip) frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom);
  endtask

  task automatic send_random_frame(frame_flaw_e flaw);
    int unsigned total;
    build_frame(flaw, pick_dim(), pick_dim());
    total = frame_q.size() + $urandom_range(4);
    if (flaw == FlTruncate) total = $urandom_range(frame_q.size() - 1);
    send_frame(total);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    model.set_register(idx, data);
  endtask

  task automatic settle();
    byte_if.valid <= 1'b0;
    while (model.verdicts_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic apply_setting(int ph);
    case (ph)
      1: begin
        write_register(CfgMaxDim, {16'($urandom), 16'hffff});
        write_register(CfgMaxBytes, 32'hffff_ffff);
      end
      2: begin
        write_register(CfgMaxDim, 32'd1);
        write_register(CfgMaxBytes, 32'd1);
        write_register(CfgSpareA, $urandom);
        write_register(CfgSpareB, $urandom);
      end
      3: begin
        write_register(CfgMaxDim, 32'd200);
        write_register(CfgMaxBytes, 32'd30000);
      end
      default: begin
        write_register(CfgMaxDim, {16'($urandom), 16'($urandom_range(16, 4096))});
        write_register(CfgMaxBytes, $urandom_range(64, 32'h40_0000));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.frame_length <= '0;
    model = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    frame_q = '{MrkFill};
    send_frame(0);
    frame_q = '{MrkFill, MrkSoi, MrkFill};
    send_frame(3);
    frame_q = '{MrkZero, MrkSoi, MrkFill, MrkSos};
    send_frame(4);
    frame_q = '{MrkFill, MrkEoi, MrkFill, MrkSos};
    send_frame(4);
    frame_q = '{MrkFill, MrkSoi, MrkFill, MrkFill, MrkFill};
    send_frame(5);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) begin
        settle();
        apply_setting(ph);
      end
      gaps_on = (ph != 1);
      build_frame(FlNone, model.max_dim, model.max_dim);
      send_frame(frame_q.size());
      if (ph == 3) hold_req = 1'b1;
      while (model.bytes_taken < (ph + 1) * ItemTarget / PhaseCount) begin
        send_random_frame($urandom_range(9) < 6 ? FlNone :
                          frame_flaw_e'($urandom_range(int'(FlNoise))));
      end
    end
    settle();

    $display("%0d frames, %0d bytes sent, five register settings incl. both extremes",
             frames_sent, model.bytes_taken);
    $display("verdicts: ok %0d, bad argument %0d, malformed %0d, unsupported %0d, size %0d",
             model.status_count[StOk], model.status_count[StArg], model.status_count[StBad],
             model.status_count[StUnsup], model.status_count[StSize]);
    if (model.mismatches == 0 && model.verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
